// ----- hdl/cbs_pkg.sv -----
package cbs_pkg;

  // Table size and number format
  localparam int MAX_POINTS = 256;
  localparam int FRAC_BITS  = 16;
  localparam int PT_W       = $clog2(MAX_POINTS);
  localparam int CNT_W      = PT_W + 1;
  localparam int COORD_W    = 32;
  localparam int PARAM_W    = 24;
  localparam int VSEL_W     = 2;

  // Blend weights: w1 and w2 carry the factor of three
  localparam int W_W        = FRAC_BITS + 2;
  localparam int PROD_W     = COORD_W + W_W + 1;
  localparam int PAIR_W     = PROD_W + 1;
  localparam int SUM_W      = PROD_W + 2;

  // Input commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Vector selectors
  localparam logic [VSEL_W-1:0] VEC_POS   = 2'd0;
  localparam logic [VSEL_W-1:0] VEC_LEFT  = 2'd1;
  localparam logic [VSEL_W-1:0] VEC_RIGHT = 2'd2;

  // One vector: index 0 is x, 1 is y, 2 is z
  typedef logic [2:0][COORD_W-1:0] coord3_t;

  // Bernstein weights of one sample
  typedef struct packed {
    logic [W_W-1:0] w0;
    logic [W_W-1:0] w1;
    logic [W_W-1:0] w2;
    logic [W_W-1:0] w3;
  } wts_t;

endpackage

// ----- hdl/cbs_weights.sv -----
module cbs_weights (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cbs_pkg::FRAC_BITS-1:0] u,
  output cbs_pkg::wts_t                 wts
);
  import cbs_pkg::*;

  localparam int F = FRAC_BITS;

  logic [F:0]     q;
  logic [2*F+1:0] qq_full;
  logic [2*F-1:0] uu_full;
  logic [F:0]     qq_r;
  logic [F-1:0]   uu_r;
  logic [F-1:0]   u_r;
  logic [F:0]     q_r;
  logic [2*F+1:0] w0_full;
  logic [2*F:0]   uqq_full;
  logic [2*F:0]   uuq_full;
  logic [2*F-1:0] w3_full;
  logic [F-1:0]   uqq;
  logic [F-1:0]   uuq;
  wts_t           wts_nxt;
  wts_t           wts_r;

  // First stage: complement and squares
  assign q       = {1'b1, {F{1'b0}}} - {1'b0, u};
  assign qq_full = q * q;
  assign uu_full = u * u;

  always_ff @(posedge clk) begin
    if (en) begin
      qq_r <= qq_full[2*F:F];
      uu_r <= uu_full[2*F-1:F];
      u_r  <= u;
      q_r  <= q;
    end
  end

  // Second stage: cubes and cross terms, cross terms times three
  assign w0_full  = qq_r * q_r;
  assign uqq_full = u_r * qq_r;
  assign uuq_full = uu_r * q_r;
  assign w3_full  = uu_r * u_r;
  assign uqq      = uqq_full[2*F-1:F];
  assign uuq      = uuq_full[2*F-1:F];

  always_comb begin
    wts_nxt.w0 = W_W'(w0_full[2*F:F]);
    wts_nxt.w1 = W_W'({uqq, 1'b0}) + W_W'(uqq);
    wts_nxt.w2 = W_W'({uuq, 1'b0}) + W_W'(uuq);
    wts_nxt.w3 = W_W'(w3_full[2*F-1:F]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wts_r <= wts_nxt;
    end
  end

  assign wts = wts_r;

endmodule

// ----- hdl/cubic_bezier_spline_sampler.sv -----
// Cubic Bezier spline sampler.
//
// Input channel (in_valid / in_ready) carries two kinds of beat. A write
// beat (in_cmd low) stores one vector (position, left or right handle) of
// control point in_point_index and yields no result. A sample beat
// (in_cmd high) evaluates segment in_curve_param[23:16] at fraction
// in_curve_param[15:0] and yields one beat on out_valid / out_ready.
// cfg_wr_en / cfg_wr_data set the number of loaded points; write it only
// while no sample is in flight.
//
// Throughput is one beat per cycle while the output is not stalled: the
// pipeline is seven register stages (table read, two weight multiply
// stages, coordinate multiply, two adder stages, shift and saturate)
// moving on a single enable.
// The control table is three 256 x 96-bit arrays (position read at two
// addresses, handles at one each); reset does not clear them.
// Reset clears the point count and all valid bits. While the receiver
// holds out_ready low with a result waiting, every stage holds and
// in_ready drops; nothing is lost or repeated.
module cubic_bezier_spline_sampler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic [cbs_pkg::PT_W-1:0]            in_point_index,
  input  logic [cbs_pkg::VSEL_W-1:0]          in_vector_select,
  input  logic signed [cbs_pkg::COORD_W-1:0]  in_coord_x,
  input  logic signed [cbs_pkg::COORD_W-1:0]  in_coord_y,
  input  logic signed [cbs_pkg::COORD_W-1:0]  in_coord_z,
  input  logic [cbs_pkg::PARAM_W-1:0]         in_curve_param,
  input  logic                                cfg_wr_en,
  input  logic [cbs_pkg::CNT_W-1:0]           cfg_wr_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cbs_pkg::COORD_W-1:0]  out_point_x,
  output logic signed [cbs_pkg::COORD_W-1:0]  out_point_y,
  output logic signed [cbs_pkg::COORD_W-1:0]  out_point_z
);
  import cbs_pkg::*;

  localparam int F = FRAC_BITS;

  logic                  en;
  logic                  accept;
  logic                  rd_en;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_lim;
  logic [CNT_W-1:0]      last_pt;
  logic [PT_W-1:0]       seg;
  logic                  at_zero;
  logic                  at_end;
  logic                  direct;
  logic [PT_W-1:0]       addr_a;
  logic [PT_W-1:0]       addr_b;
  logic [F-1:0]          u_nxt;
  logic                  pos_we;
  logic                  left_we;
  logic                  right_we;
  coord3_t               wr_vec;

  coord3_t               pos_mem   [MAX_POINTS];
  coord3_t               left_mem  [MAX_POINTS];
  coord3_t               right_mem [MAX_POINTS];

  logic                  v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic                  zero1_r;
  logic                  blend1_r;
  logic [F-1:0]          u1_r;
  coord3_t               pa1_r, pb1_r, lh1_r, rh1_r;
  coord3_t               pa2_r, pb2_r, lh2_r, rh2_r;
  coord3_t               pa3_r, pb3_r, lh3_r, rh3_r;
  wts_t                  wts;

  logic signed [PROD_W-1:0] prod_nxt [3][4];
  logic signed [PROD_W-1:0] prod4_r  [3][4];
  logic signed [PAIR_W-1:0] pair5_r  [3][2];
  logic signed [SUM_W-1:0]  sum6_r   [3];
  logic signed [SUM_W-1:0]  shifted  [3];
  coord3_t                  res_nxt;
  coord3_t                  res_r;
  logic                     out_valid_r;

  // Single enable: move all stages unless a result is stuck at the output
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;
  assign rd_en    = accept && (in_cmd == CMD_SAMPLE);

  // Point count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // Segment selection and end cases
  always_comb begin
    count_lim = (count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_r;
    last_pt   = count_lim - CNT_W'(1);
    seg       = PT_W'(in_curve_param[PARAM_W-1:F]);
    at_zero   = (in_curve_param == '0);
    at_end    = ({1'b0, seg} >= last_pt);
    direct    = at_zero || at_end;
    if (at_zero) begin
      addr_a = '0;
    end else if (at_end) begin
      addr_a = last_pt[PT_W-1:0];
    end else begin
      addr_a = seg;
    end
    addr_b = seg + PT_W'(1);
    u_nxt  = direct ? '0 : in_curve_param[F-1:0];
  end

  // Decode the vector a write beat targets
  always_comb begin
    pos_we   = 1'b0;
    left_we  = 1'b0;
    right_we = 1'b0;
    if (accept && (in_cmd == CMD_WRITE)) begin
      unique case (in_vector_select)
        VEC_POS:   pos_we   = 1'b1;
        VEC_LEFT:  left_we  = 1'b1;
        VEC_RIGHT: right_we = 1'b1;
        default: ;
      endcase
    end
  end

  assign wr_vec = {in_coord_z, in_coord_y, in_coord_x};

  // Control table: write one vector, read four on a sample
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[in_point_index] <= wr_vec;
    end
    if (rd_en) begin
      pa1_r <= pos_mem[addr_a];
      pb1_r <= pos_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[in_point_index] <= wr_vec;
    end
    if (rd_en) begin
      lh1_r <= left_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (right_we) begin
      right_mem[in_point_index] <= wr_vec;
    end
    if (rd_en) begin
      rh1_r <= right_mem[seg];
    end
  end

  // Stage 1 sideband; an empty curve blends nothing
  always_ff @(posedge clk) begin
    if (rd_en) begin
      zero1_r  <= (count_lim == '0);
      blend1_r <= !direct && (count_lim != '0);
      u1_r     <= u_nxt;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= rd_en;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      out_valid_r <= v6_r;
    end
  end

  // Stage 2: drop control points that carry no weight
  always_ff @(posedge clk) begin
    if (en) begin
      pa2_r <= zero1_r ? '0 : pa1_r;
      pb2_r <= blend1_r ? pb1_r : '0;
      lh2_r <= blend1_r ? lh1_r : '0;
      rh2_r <= blend1_r ? rh1_r : '0;
    end
  end

  // Stages 2 and 3 of the weights
  cbs_weights u_weights (
    .clk (clk),
    .en  (en),
    .u   (u1_r),
    .wts (wts)
  );

  // Stage 3: hold points beside the weights
  always_ff @(posedge clk) begin
    if (en) begin
      pa3_r <= pa2_r;
      pb3_r <= pb2_r;
      lh3_r <= lh2_r;
      rh3_r <= rh2_r;
    end
  end

  // Stage 4: weight times coordinate
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_nxt[a][0] = $signed({1'b0, wts.w0}) * $signed(pa3_r[a]);
      prod_nxt[a][1] = $signed({1'b0, wts.w1}) * $signed(rh3_r[a]);
      prod_nxt[a][2] = $signed({1'b0, wts.w2}) * $signed(lh3_r[a]);
      prod_nxt[a][3] = $signed({1'b0, wts.w3}) * $signed(pb3_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod4_r <= prod_nxt;
    end
  end

  // Stages 5 and 6: add the four terms
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        pair5_r[a][0] <= PAIR_W'(prod4_r[a][0]) + PAIR_W'(prod4_r[a][1]);
        pair5_r[a][1] <= PAIR_W'(prod4_r[a][2]) + PAIR_W'(prod4_r[a][3]);
        sum6_r[a]     <= SUM_W'(pair5_r[a][0]) + SUM_W'(pair5_r[a][1]);
      end
    end
  end

  // Stage 7: floor shift, saturate to 32 bits
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      shifted[a] = sum6_r[a] >>> F;
      if (&shifted[a][SUM_W-1:COORD_W-1] || ~|shifted[a][SUM_W-1:COORD_W-1]) begin
        res_nxt[a] = shifted[a][COORD_W-1:0];
      end else if (shifted[a][SUM_W-1]) begin
        res_nxt[a] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        res_nxt[a] = {1'b0, {(COORD_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_point_x = res_r[0];
  assign out_point_y = res_r[1];
  assign out_point_z = res_r[2];

endmodule

// ----- hdl/cbs_checker.sv -----
module cbs_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [cbs_pkg::COORD_W-1:0] out_point_x,
  input logic signed [cbs_pkg::COORD_W-1:0] out_point_y,
  input logic signed [cbs_pkg::COORD_W-1:0] out_point_z
);
  import cbs_pkg::*;

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Accept input whenever the output side can move
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low with output free");

  // Stall holds the result beat
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_point_x) && $stable(out_point_y)
       && $stable(out_point_z)))
    else $error("result changed during stall");

endmodule

bind cubic_bezier_spline_sampler cbs_checker u_cbs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_point_x (out_point_x),
  .out_point_y (out_point_y),
  .out_point_z (out_point_z)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import cbs_pkg::*;

  localparam int          RAND_BEATS    = 1050;
  localparam int          SETTLE_CYCLES = 14;
  localparam int          HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam longint      Q_MAX         = 64'sh0000_0000_7FFF_FFFF;
  localparam longint      Q_MIN         = -64'sh0000_0000_8000_0000;

  // Selector value the block must ignore on a write
  localparam logic [VSEL_W-1:0] VEC_UNUSED = 2'd3;

  typedef enum logic [1:0] {ROW_COUNT, ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // One stimulus step: a point-count setting or an input beat
  typedef struct packed {
    row_kind_t                 kind;
    logic [CNT_W-1:0]          slot;
    logic [VSEL_W-1:0]         vsel;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [PARAM_W-1:0]        t;
    logic                      fixed;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic signed [COORD_W-1:0] ez;
  } step_t;

  // Directed steps: empty curve, table extremes, ignored write, clamped count
  localparam step_t DIR_TAB [24] = '{
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h123456,
      1'b1, 32'h0, 32'h0, 32'h0},
    '{ROW_WRITE, 9'd0, VEC_POS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 24'hFFFFFF,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_WRITE, 9'd0, VEC_LEFT, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0005, 24'h0,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_WRITE, 9'd0, VEC_RIGHT, 32'h0002_0000, 32'hFFFE_0000, 32'h7FFF_FFFF, 24'h0,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_WRITE, 9'd1, VEC_LEFT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000, 24'h0,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_WRITE, 9'd1, VEC_POS, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 24'h0,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_WRITE, 9'd1, VEC_RIGHT, 32'h1234_5678, 32'hEDCB_A988, 32'h0000_0000, 24'h0,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_WRITE, 9'd255, VEC_POS, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 24'h0,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_WRITE, 9'd0, VEC_UNUSED, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 24'h0,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_COUNT, 9'd1, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h0,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h000000,
      1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000},
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'hFFFFFF,
      1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000},
    '{ROW_COUNT, 9'd2, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h0,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h000000,
      1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000},
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h010000,
      1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000},
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h008000,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h000001,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h00FFFF,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_COUNT, 9'd511, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h0,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'hFFFFFF,
      1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F},
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'hFF0000,
      1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F},
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h000000,
      1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000},
    '{ROW_COUNT, 9'd256, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h0,
      1'b0, 32'h0, 32'h0, 32'h0},
    '{ROW_SAMPLE, 9'd0, VEC_POS, 32'h0, 32'h0, 32'h0, 24'h00C000,
      1'b0, 32'h0, 32'h0, 32'h0}
  };

  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic                      in_cmd           = CMD_WRITE;
  logic [PT_W-1:0]           in_point_index   = '0;
  logic [VSEL_W-1:0]         in_vector_select = VEC_POS;
  logic signed [COORD_W-1:0] in_coord_x       = '0;
  logic signed [COORD_W-1:0] in_coord_y       = '0;
  logic signed [COORD_W-1:0] in_coord_z       = '0;
  logic [PARAM_W-1:0]        in_curve_param   = '0;
  logic                      cfg_wr_en        = 1'b0;
  logic [CNT_W-1:0]          cfg_wr_data      = '0;
  logic                      out_valid;
  logic                      out_ready        = 1'b0;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic signed [COORD_W-1:0] out_point_z;

  // Local copy of the control table and the point count
  bit signed [COORD_W-1:0] ctl_pts [MAX_POINTS][3][3];
  bit                      loaded  [MAX_POINTS][3];
  int unsigned             curve_count = 0;

  coord3_t     due_points [$];
  int unsigned bad_beats      = 0;
  int unsigned write_beats    = 0;
  int unsigned sample_beats   = 0;
  int unsigned points_checked = 0;
  int unsigned count_settings = 0;
  bit          calm           = 1'b0;
  bit          hold_off_due   = 1'b0;

  always #6 clk = ~clk;

  cubic_bezier_spline_sampler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_point_index   (in_point_index),
    .in_vector_select (in_vector_select),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_curve_param   (in_curve_param),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_z      (out_point_z)
  );

  // Cubic Bernstein blend of one segment, truncating products
  function automatic coord3_t bezier_point(input logic [PARAM_W-1:0] t);
    coord3_t     pt;
    int unsigned n, k, src;
    int          a;
    longint      u, q, qq, uu, w0, w1, w2, w3, acc;
    pt = '0;
    n = (curve_count > MAX_POINTS) ? MAX_POINTS : curve_count;
    if (n == 0) return pt;
    // Start of curve and anything at or past the last point
    if (t == 0 || 32'(t) >= ((n - 1) << FRAC_BITS)) begin
      src = (t == 0) ? 0 : n - 1;
      for (a = 0; a < 3; a++) pt[a] = ctl_pts[src][VEC_POS][a];
      return pt;
    end
    k  = 32'(t >> FRAC_BITS);
    u  = longint'(t[FRAC_BITS-1:0]);
    q  = (longint'(1) << FRAC_BITS) - u;
    qq = (q * q) >> FRAC_BITS;
    uu = (u * u) >> FRAC_BITS;
    w0 = (qq * q) >> FRAC_BITS;
    w1 = 3 * ((u * qq) >> FRAC_BITS);
    w2 = 3 * ((uu * q) >> FRAC_BITS);
    w3 = (uu * u) >> FRAC_BITS;
    for (a = 0; a < 3; a++) begin
      acc = w0 * longint'(ctl_pts[k][VEC_POS][a])
          + w1 * longint'(ctl_pts[k][VEC_RIGHT][a])
          + w2 * longint'(ctl_pts[k+1][VEC_LEFT][a])
          + w3 * longint'(ctl_pts[k+1][VEC_POS][a]);
      acc = acc >>> FRAC_BITS;
      if (acc > Q_MAX) acc = Q_MAX;
      if (acc < Q_MIN) acc = Q_MIN;
      pt[a] = acc[COORD_W-1:0];
    end
    return pt;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $signed($urandom) >>> 12;
      default: return $urandom;
    endcase
  endfunction

  function automatic step_t write_step(input int unsigned pt, input logic [VSEL_W-1:0] v);
    step_t s;
    s      = '0;
    s.kind = ROW_WRITE;
    s.slot = pt[CNT_W-1:0];
    s.vsel = v;
    s.x    = rand_coord();
    s.y    = rand_coord();
    s.z    = rand_coord();
    s.t    = PARAM_W'($urandom_range(0, 24'hFFFFFF));
    return s;
  endfunction

  // Offer one beat, hold it until accepted, then update the local table or queue the expected result
  task automatic push_beat(input step_t s);
    int      gap;
    coord3_t want;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= (s.kind == ROW_SAMPLE) ? CMD_SAMPLE : CMD_WRITE;
    in_point_index   <= s.slot[PT_W-1:0];
    in_vector_select <= s.vsel;
    in_coord_x       <= s.x;
    in_coord_y       <= s.y;
    in_coord_z       <= s.z;
    in_curve_param   <= s.t;
    do @(posedge clk); while (!in_ready);
    if (s.kind == ROW_WRITE) begin
      write_beats++;
      if (s.vsel != VEC_UNUSED) begin
        ctl_pts[s.slot[PT_W-1:0]][s.vsel][0] = s.x;
        ctl_pts[s.slot[PT_W-1:0]][s.vsel][1] = s.y;
        ctl_pts[s.slot[PT_W-1:0]][s.vsel][2] = s.z;
        loaded[s.slot[PT_W-1:0]][s.vsel]     = 1'b1;
      end
    end else begin
      sample_beats++;
      if (s.fixed) begin
        want[0] = s.ex;
        want[1] = s.ey;
        want[2] = s.ez;
      end else begin
        want = bezier_point(s.t);
      end
      due_points.insert(due_points.size(), want);
    end
  endtask

  // Drain the pipe, let trailing writes settle, then set the point count
  task automatic load_count(input int unsigned c);
    in_valid <= 1'b0;
    while (due_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c[CNT_W-1:0];
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    curve_count = c;
    count_settings++;
  endtask

  // Result side: check each beat, stall at random, one long hold-off
  initial begin
    int      stall_left;
    int      hold_left;
    coord3_t got;
    coord3_t want;
    stall_left = 0;
    hold_left  = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got[0] = out_point_x;
        got[1] = out_point_y;
        got[2] = out_point_z;
        if (due_points.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("%0t: unexpected result beat x=%h y=%h z=%h",
                     $time, got[0], got[1], got[2]);
        end else begin
          want = due_points.pop_front();
          points_checked++;
          if (got !== want) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("%0t: result mismatch, expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                       $time, want[0], want[1], want[2], got[0], got[1], got[2]);
          end
        end
      end
      if (hold_off_due) begin
        hold_off_due = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = draw_gap();
      end
    end
  end

  // Watchdog
  initial begin
    int unsigned cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Run timed out after %0d cycles", cycle_cnt);
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    step_t       s;
    int unsigned rand_beats, phase_no, c, n, lo, hi, p, k, v, r;
    int unsigned seg_ok [$];
    rand_beats = 0;
    phase_no   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    for (int i = 0; i < $size(DIR_TAB); i++) begin
      if (DIR_TAB[i].kind == ROW_COUNT) load_count(32'(DIR_TAB[i].slot));
      else push_beat(DIR_TAB[i]);
    end

    // Random phases, each under its own point count
    while (rand_beats < RAND_BEATS) begin
      case ($urandom_range(0, 9))
        0:       c = 0;
        1:       c = 1;
        2:       c = 2;
        3, 4, 5: c = $urandom_range(3, 12);
        6:       c = $urandom_range(13, 255);
        7:       c = MAX_POINTS;
        8:       c = $urandom_range(257, 511);
        default: c = 511;
      endcase
      load_count(c);
      n    = (c > MAX_POINTS) ? MAX_POINTS : c;
      calm = ($urandom_range(0, 4) == 0);

      // Load both ends and a run of complete points
      if (n > 0) begin
        push_beat(write_step(0, VEC_POS));
        push_beat(write_step(n - 1, VEC_POS));
        lo = $urandom_range(0, n - 1);
        hi = lo + $urandom_range(1, 5);
        if (hi > n - 1) hi = n - 1;
        for (p = lo; p <= hi; p++) begin
          for (v = 0; v < 3; v++) push_beat(write_step(p, v[VSEL_W-1:0]));
        end
        rand_beats += 2 + 3 * (hi - lo + 1);
      end

      if (phase_no == 2) hold_off_due = 1'b1;

      repeat ($urandom_range(20, 50)) begin
        r = $urandom_range(0, 99);
        if (r < 22) begin
          // Mostly inside the loaded span, sometimes anywhere, rarely a bad selector
          p = (n > 0 && r < 16) ? $urandom_range(0, n - 1) : $urandom_range(0, 255);
          s = write_step(p, ($urandom_range(0, 15) == 0) ? VEC_UNUSED
                                                         : 2'($urandom_range(0, 2)));
        end else begin
          s      = write_step($urandom_range(0, 255), 2'($urandom_range(0, 3)));
          s.kind = ROW_SAMPLE;
          if (n == 0) begin
            s.t = PARAM_W'($urandom_range(0, 24'hFFFFFF));
          end else if (r < 30) begin
            s.t = '0;
          end else if (r < 38) begin
            s.t = PARAM_W'($urandom_range((n - 1) << FRAC_BITS, 24'hFFFFFF));
          end else begin
            // Only segments whose four control vectors are loaded
            seg_ok.delete();
            for (k = 0; k + 1 < n; k++) begin
              if (loaded[k][VEC_POS] && loaded[k][VEC_RIGHT] &&
                  loaded[k+1][VEC_LEFT] && loaded[k+1][VEC_POS])
                seg_ok.insert(seg_ok.size(), k);
            end
            if (seg_ok.size() == 0) begin
              s.t = '0;
            end else begin
              k = seg_ok[$urandom_range(0, seg_ok.size() - 1)];
              case ($urandom_range(0, 9))
                0:       s.t = {k[PARAM_W-FRAC_BITS-1:0], 16'h0000};
                1:       s.t = {k[PARAM_W-FRAC_BITS-1:0], 16'hFFFF};
                default: s.t = {k[PARAM_W-FRAC_BITS-1:0], 16'($urandom)};
              endcase
            end
          end
        end
        push_beat(s);
        if (!(s.kind == ROW_WRITE && s.vsel == VEC_UNUSED)) rand_beats++;
      end
      phase_no++;
    end

    // Drop valid, drain, and let the pipe settle
    in_valid <= 1'b0;
    while (due_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d write beats and %0d sample beats; %0d sampled points checked",
             write_beats, sample_beats, points_checked);
    $display("Covered %0d point-count settings and one long output hold-off", count_settings);
    if (bad_beats == 0 && due_points.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d bad result beats, %0d results missing", bad_beats, due_points.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
